// ===== rtl/softmax_forward_backward_core_assert.svh =====
// Assertion macros for the softmax forward/backward core.
// Depends on nothing; included by the top level only.
`ifndef SOFTMAX_FORWARD_BACKWARD_CORE_ASSERT_SVH
`define SOFTMAX_FORWARD_BACKWARD_CORE_ASSERT_SVH

// same-cycle implication
`define SMFB_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SMFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/smfb_pkg.sv =====
// Shared types, widths and the 2^(-i/16) table for the softmax core.
// No dependencies.
package smfb_pkg;

  localparam int unsigned VAL_W    = 16;
  localparam int unsigned EXP_W    = 17;
  localparam int unsigned RES_W    = 17;
  localparam int unsigned SUM_W    = 23;
  localparam int unsigned WSUM_W   = 40;
  localparam int unsigned DIV_DW   = 58;
  localparam int unsigned DIV_VW   = 46;
  localparam int unsigned DIV_CW   = $clog2(DIV_DW + 1);
  localparam logic [10:0] LOG2E_Q10 = 11'd1477;

  typedef struct packed {
    logic              start;
    logic [DIV_DW-1:0] dividend;
    logic [DIV_VW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_DW-1:0] quot;
  } div_rsp_t;

  // 2^(-i/16) in Q1.16, i = 0..16
  function automatic logic [EXP_W-1:0] pow2_tab(input logic [4:0] i);
    logic [EXP_W-1:0] t;
    unique case (i)
      5'd0:    t = 17'd65536;
      5'd1:    t = 17'd62757;
      5'd2:    t = 17'd60097;
      5'd3:    t = 17'd57549;
      5'd4:    t = 17'd55109;
      5'd5:    t = 17'd52773;
      5'd6:    t = 17'd50535;
      5'd7:    t = 17'd48393;
      5'd8:    t = 17'd46341;
      5'd9:    t = 17'd44376;
      5'd10:   t = 17'd42495;
      5'd11:   t = 17'd40693;
      5'd12:   t = 17'd38968;
      5'd13:   t = 17'd37316;
      5'd14:   t = 17'd35734;
      5'd15:   t = 17'd34219;
      5'd16:   t = 17'd32768;
      default: t = '0;
    endcase
    return t;
  endfunction

endpackage

// ===== rtl/smfb_in_if.sv =====
// Input channel of the softmax core: valid/ready plus one element.
// Depends on nothing.
interface smfb_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] value;
  logic [16:0]        exp_in;
  logic               last;

  modport source (output valid, value, exp_in, last, input ready);
  modport sink   (input valid, value, exp_in, last, output ready);
endinterface

// ===== rtl/smfb_out_if.sv =====
// Output channel of the softmax core: valid/ready plus one result.
// Depends on nothing.
interface smfb_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] result;
  logic [16:0]        exp_out;
  logic               error;
  logic               last_out;

  modport source (output valid, result, exp_out, error, last_out, input ready);
  modport sink   (input valid, result, exp_out, error, last_out, output ready);
endinterface

// ===== rtl/smfb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smfb_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== rtl/smfb_exp.sv =====
// Two-stage fixed-point exp(-k/1024) unit: 2^-y by table plus linear interpolation.
// Depends on smfb_pkg.
module smfb_exp import smfb_pkg::*; (
  input  logic             clk_i,
  input  logic [15:0]      k_i,
  output logic [EXP_W-1:0] e_o
);
  logic [26:0]      prod;
  logic [16:0]      y_q;
  logic [6:0]       n;
  logic [4:0]       ti;
  logic [5:0]       lo;
  logic [EXP_W-1:0] t0, t1, v;
  logic [11:0]      dlt;
  logic [17:0]      interp;
  logic [17:0]      rnd, sum;

  // stage 1: k * log2(e) in Q10
  assign prod = 27'(k_i) * 27'(LOG2E_Q10);

  always_ff @(posedge clk_i) begin
    y_q <= prod[26:10];
  end

  // stage 2: table read, interpolate, shift with rounding
  assign n      = y_q[16:10];
  assign ti     = {1'b0, y_q[9:6]};
  assign lo     = y_q[5:0];
  assign t0     = pow2_tab(ti);
  assign t1     = pow2_tab(ti + 5'd1);
  assign dlt    = 12'(t0 - t1);
  assign interp = (18'(dlt) * 18'(lo) + 18'd32) >> 6;
  assign v      = 17'(18'(t0) - interp);
  assign rnd    = 18'd1 << (n[4:0] - 5'd1);
  assign sum    = 18'(v) + rnd;

  always_comb begin
    if (n >= 7'd17) begin
      e_o = '0;
    end else if (n == 7'd0) begin
      e_o = v;
    end else begin
      e_o = 17'(sum >> n[4:0]);
    end
  end
endmodule

// ===== rtl/smfb_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle, shared by both modes.
// Depends on smfb_pkg.
module smfb_div import smfb_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);
  logic [DIV_DW-1:0] num_q, num_d;
  logic [DIV_VW-1:0] rem_q, rem_d, den_q, den_d;
  logic [DIV_CW-1:0] cnt_q, cnt_d;
  logic              busy_q, busy_d, done_q, done_d;
  logic [DIV_VW:0]   trial, diffv;
  logic              ge;

  assign trial = {rem_q, num_q[DIV_DW-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diffv = trial - {1'b0, den_q};

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (req_i.start) begin
      num_d  = req_i.dividend;
      rem_d  = '0;
      den_d  = req_i.divisor;
      cnt_d  = DIV_CW'(DIV_DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diffv[DIV_VW-1:0] : trial[DIV_VW-1:0];
      num_d = {num_q[DIV_DW-2:0], ge};
      cnt_d = cnt_q - DIV_CW'(1);
      if (cnt_q == DIV_CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = num_q;
endmodule

// ===== rtl/softmax_forward_backward_core.sv =====
// Top level of the fixed-point softmax forward/backward core.
// Depends on smfb_pkg, smfb_in_if, smfb_out_if, smfb_ram, smfb_exp, smfb_div and the assertion header.
//
//  channel   dir  handshake          payload
//  in_i      in   valid/ready        value, exp_in, last
//  out_o     out  valid/ready        result, exp_out, error, last_out
//  cfg       in   cfg_we_i (no wait) cfg_wdata_i = direction
//
// Loading: an element can be taken in every cycle; in_i.ready is high only while loading.
// Forward: a sum pass rebuilds S from the computed exponents, then each result waits on the
// serial divider. Backward: S*S is formed once, then each result also goes through the divider.
// The shared divider sets the emit rate; a stalled output only holds the next result.
// Reset is asynchronous, active low; the stores need no clearing.
`include "softmax_forward_backward_core_assert.svh"

module softmax_forward_backward_core import smfb_pkg::*; #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  smfb_in_if.sink     in_i,
  smfb_out_if.source  out_o
);
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned AW = $clog2(MAX_LEN);

  typedef enum logic [11:0] {
    S_LOAD = 12'b000000000001,
    S_SQ   = 12'b000000000010,  // S*S for backward
    S_RD   = 12'b000000000100,
    S_X1   = 12'b000000001000,
    S_X2   = 12'b000000010000,
    S_X3   = 12'b000000100000,
    S_B2   = 12'b000001000000,
    S_B3   = 12'b000010000000,
    S_B4   = 12'b000100000000,
    S_B5   = 12'b001000000000,
    S_DIV  = 12'b010000000000,
    S_OUT  = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  // control
  logic              dir_q, dir_d;
  logic [CW-1:0]     cnt_q, cnt_d, idx_q, idx_d;
  logic              ovf_q, ovf_d;
  logic              sum_pass_q, sum_pass_d;
  logic              out_vld_q, out_vld_d;

  // vector accumulators
  logic signed [VAL_W-1:0]  max_q, max_d;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic signed [WSUM_W-1:0] wsum_q, wsum_d;

  // datapath
  logic [DIV_VW-1:0]        s2_q, s2_d;
  logic [EXP_W-1:0]         ex_q, ex_d;
  logic signed [WSUM_W-1:0] gs_q, gs_d;
  logic                     neg_q, neg_d;
  logic [WSUM_W-1:0]        mag_q, mag_d;
  logic [36:0]              plo_q, plo_d, phi_q, phi_d;
  logic signed [RES_W-1:0]  res_q, res_d;
  logic signed [RES_W-1:0]  out_res_q, out_res_d;
  logic [EXP_W-1:0]         out_exp_q, out_exp_d;
  logic                     out_err_q, out_err_d, out_last_q, out_last_d;

  logic                     acc, store, last_here, out_load;
  logic [32:0]              rdata;
  logic signed [VAL_W-1:0]  rd_val;
  logic signed [16:0]       kd;
  logic [EXP_W-1:0]         exp_e;
  logic signed [33:0]       wprod;
  logic signed [40:0]       diff;
  logic [DIV_DW-1:0]        q;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  assign acc       = in_i.valid && in_i.ready;
  assign store     = acc && (cnt_q < CW'(MAX_LEN));
  assign last_here = idx_q == CW'(cnt_q - CW'(1));
  assign out_load  = (state_q == S_OUT) && (!out_vld_q || out_o.ready);
  assign in_i.ready = state_q == S_LOAD;

  smfb_ram #(.WIDTH(33), .DEPTH(MAX_LEN)) u_store (
    .clk_i   (clk_i),
    .we_i    (store),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i ({in_i.exp_in, in_i.value}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  assign rd_val = rdata[15:0];
  assign kd     = {max_q[15], max_q} - {rd_val[15], rd_val};

  smfb_exp u_exp (
    .clk_i (clk_i),
    .k_i   (kd[15:0]),
    .e_o   (exp_e)
  );

  smfb_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign wprod = $signed({1'b0, in_i.exp_in}) * in_i.value;
  assign diff  = 41'(gs_q) - 41'(wsum_q);
  assign q     = div_rsp.quot;

  always_comb begin
    div_req.start    = 1'b0;
    div_req.dividend = DIV_DW'({ex_q, 16'b0}) + DIV_DW'(sum_q >> 1);
    div_req.divisor  = DIV_VW'(sum_q);
    if (state_q == S_B5) begin
      div_req.dividend = DIV_DW'({phi_q, 20'b0}) + DIV_DW'(plo_q) + DIV_DW'(s2_q >> 1);
      div_req.divisor  = s2_q;
      div_req.start    = 1'b1;
    end else if (state_q == S_X3 && !sum_pass_q) begin
      div_req.start    = 1'b1;
    end
  end

  always_comb begin
    state_d    = state_q;
    dir_d      = cfg_we_i ? cfg_wdata_i : dir_q;
    cnt_d      = cnt_q;
    idx_d      = idx_q;
    ovf_d      = ovf_q;
    sum_pass_d = sum_pass_q;
    max_d      = max_q;
    sum_d      = sum_q;
    wsum_d     = wsum_q;
    s2_d       = s2_q;
    ex_d       = ex_q;
    gs_d       = gs_q;
    neg_d      = neg_q;
    mag_d      = mag_q;
    plo_d      = plo_q;
    phi_d      = phi_q;
    res_d      = res_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_res_d  = out_res_q;
    out_exp_d  = out_exp_q;
    out_err_d  = out_err_q;
    out_last_d = out_last_q;

    unique case (state_q)
      S_LOAD: begin
        if (acc) begin
          if (store) begin
            cnt_d  = cnt_q + CW'(1);
            sum_d  = sum_q + SUM_W'(in_i.exp_in);
            wsum_d = wsum_q + WSUM_W'(wprod);
            if (in_i.value > max_q) begin
              max_d = in_i.value;
            end
          end else begin
            ovf_d = 1'b1;
          end
          if (in_i.last) begin
            idx_d = '0;
            if (!dir_q) begin
              sum_d      = '0;  // forward rebuilds S from computed exponents
              sum_pass_d = 1'b1;
              state_d    = S_RD;
            end else begin
              state_d = S_SQ;
            end
          end
        end
      end
      S_SQ: begin
        s2_d    = DIV_VW'(sum_q) * DIV_VW'(sum_q);
        state_d = S_RD;
      end
      S_RD: state_d = S_X1;
      S_X1: begin
        if (!dir_q) begin
          state_d = S_X2;
        end else begin
          gs_d    = rd_val * $signed({1'b0, sum_q});
          ex_d    = rdata[32:16];
          state_d = S_B2;
        end
      end
      S_X2: begin
        ex_d    = exp_e;
        state_d = S_X3;
      end
      S_X3: begin
        if (sum_pass_q) begin
          sum_d = sum_q + SUM_W'(ex_q);
          if (last_here) begin
            sum_pass_d = 1'b0;
            idx_d      = '0;
          end else begin
            idx_d = idx_q + CW'(1);
          end
          state_d = S_RD;
        end else begin
          state_d = S_DIV;
        end
      end
      S_B2: begin
        neg_d   = diff[40];
        mag_d   = diff[40] ? WSUM_W'(-diff) : WSUM_W'(diff);
        state_d = S_B3;
      end
      S_B3: begin
        plo_d   = 37'(ex_q) * 37'(mag_q[19:0]);
        state_d = S_B4;
      end
      S_B4: begin
        phi_d   = 37'(ex_q) * 37'(mag_q[39:20]);
        state_d = S_B5;
      end
      S_B5: state_d = S_DIV;
      S_DIV: begin
        if (div_rsp.done) begin
          if (!dir_q) begin
            res_d = (q > DIV_DW'(65535)) ? 17'sd65535 : RES_W'(q);
          end else if (s2_q == '0) begin
            res_d = '0;
          end else if (neg_q) begin
            res_d = (q > DIV_DW'(65536)) ? 17'h10000 : RES_W'(~q[16:0] + 17'd1);
          end else begin
            res_d = (q > DIV_DW'(65535)) ? 17'sd65535 : RES_W'(q);
          end
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          out_vld_d  = 1'b1;
          out_res_d  = res_q;
          out_exp_d  = dir_q ? '0 : ex_q;
          out_err_d  = ovf_q;
          out_last_d = last_here;
          if (last_here) begin
            // vector closed: back to the post-reset accumulators
            cnt_d   = '0;
            max_d   = 16'sh8000;
            sum_d   = '0;
            wsum_d  = '0;
            ovf_d   = 1'b0;
            state_d = S_LOAD;
          end else begin
            idx_d   = idx_q + CW'(1);
            state_d = S_RD;
          end
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LOAD;
      dir_q      <= 1'b0;
      cnt_q      <= '0;
      idx_q      <= '0;
      ovf_q      <= 1'b0;
      sum_pass_q <= 1'b0;
      max_q      <= 16'sh8000;
      sum_q      <= '0;
      wsum_q     <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      dir_q      <= dir_d;
      cnt_q      <= cnt_d;
      idx_q      <= idx_d;
      ovf_q      <= ovf_d;
      sum_pass_q <= sum_pass_d;
      max_q      <= max_d;
      sum_q      <= sum_d;
      wsum_q     <= wsum_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_q       <= s2_d;
    ex_q       <= ex_d;
    gs_q       <= gs_d;
    neg_q      <= neg_d;
    mag_q      <= mag_d;
    plo_q      <= plo_d;
    phi_q      <= phi_d;
    res_q      <= res_d;
    out_res_q  <= out_res_d;
    out_exp_q  <= out_exp_d;
    out_err_q  <= out_err_d;
    out_last_q <= out_last_d;
  end

  assign out_o.valid    = out_vld_q;
  assign out_o.result   = out_res_q;
  assign out_o.exp_out  = out_exp_q;
  assign out_o.error    = out_err_q;
  assign out_o.last_out = out_last_q;

  `SMFB_ASSERT_IMPLY(a_cnt_range, clk_i, rst_ni, 1'b1, cnt_q <= CW'(MAX_LEN), "count past MAX_LEN")
  `SMFB_ASSERT_IMPLY(a_div_idle, clk_i, rst_ni, div_req.start, !div_rsp.busy, "divider restarted while busy")
  `SMFB_ASSERT_NEXT(a_close, clk_i, rst_ni, out_load && last_here, state_q == S_LOAD && cnt_q == '0, "vector not closed")

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for softmax_forward_backward_core.
// Depends on smfb_pkg, smfb_in_if, smfb_out_if and the core RTL; predicts each
// result in SystemVerilog and compares it with what the block emits.
`timescale 1ns / 1ps

module tb_top import smfb_pkg::*; ();

  localparam int unsigned MAX_LEN = 64;

  // forward / backward selector, as written to the register
  typedef enum logic {DIR_FORWARD = 1'b0, DIR_BACKWARD = 1'b1} dir_e;

  typedef struct {
    logic signed [RES_W-1:0] result;
    logic [EXP_W-1:0]        exp_out;
    logic                    error;
    logic                    last_out;
  } softmax_res_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  smfb_in_if  in_if ();
  smfb_out_if out_if ();

  softmax_forward_backward_core #(.MAX_LEN(MAX_LEN)) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  // Predictor state: mirrors the vector being loaded.
  logic signed [VAL_W-1:0] vec_value [MAX_LEN];
  logic [EXP_W-1:0]        vec_exp   [MAX_LEN];
  int                      vec_len;
  int                      vec_max;
  longint                  vec_exp_sum;
  longint                  vec_grad_sum;
  bit                      vec_dropped;
  dir_e                    direction;

  softmax_res_t softmax_q[$];

  int  mismatches;
  int  results_seen;
  int  items_sent;
  int  vectors_sent;
  bit  no_gaps;        // both sides run without idling
  int  hold_cycles;    // receiver hold-off, counted down by the sink
  int  out_wait;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

  // exp(-k/1024) in Q1.16: base-2 split, table lookup, linear interpolation
  function automatic int unsigned exp_q16(input int unsigned k);
    int unsigned y, n, f, i, lo, v;
    int unsigned tab [17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535,
                              48393, 46341, 44376, 42495, 40693, 38968, 37316,
                              35734, 34219, 32768};
    y  = (k * 1477) >> 10;
    n  = y >> 10;
    f  = y & 1023;
    i  = f >> 6;
    lo = f & 63;
    v  = tab[i] - (((tab[i] - tab[i+1]) * lo + 32) >> 6);
    if (n >= 17) return 0;
    if (n == 0) return v;
    return (v + (1 << (n - 1))) >> n;
  endfunction

  // Fold one accepted item into the vector; on the closing item queue
  // every result the block owes.
  task automatic predict_softmax(input logic signed [VAL_W-1:0] x,
                                 input logic [EXP_W-1:0] e_in, input logic last);
    int unsigned  s, e;
    longint       s_b, num, q, s2, mag, r, p;
    softmax_res_t res;
    if (vec_len < MAX_LEN) begin
      vec_value[vec_len] = x;
      vec_exp[vec_len]   = e_in;
      vec_len++;
      if (int'(x) > vec_max) vec_max = int'(x);
      vec_exp_sum  += longint'(e_in);
      vec_grad_sum += longint'(e_in) * longint'(x);
    end else begin
      vec_dropped = 1'b1;
    end
    if (!last) return;
    vectors_sent++;
    if (direction == DIR_FORWARD) begin
      s = 0;
      for (int j = 0; j < vec_len; j++) s += exp_q16(vec_max - int'(vec_value[j]));
      for (int j = 0; j < vec_len; j++) begin
        e = exp_q16(vec_max - int'(vec_value[j]));
        p = (s != 0) ? ((longint'(e) << 16) + s / 2) / s : 0;
        if (p > 65535) p = 65535;
        res.result   = p[RES_W-1:0];
        res.exp_out  = e[EXP_W-1:0];
        res.error    = vec_dropped;
        res.last_out = (j + 1 == vec_len);
        softmax_q.push_back(res);
      end
    end else begin
      s_b = vec_exp_sum;
      s2  = s_b * s_b;
      for (int j = 0; j < vec_len; j++) begin
        r = 0;
        if (s2 != 0) begin
          num = longint'(vec_exp[j]) * (longint'(vec_value[j]) * s_b - vec_grad_sum);
          mag = (num < 0) ? -num : num;
          q   = (mag + s2 / 2) / s2;   // halves away from zero
          if (num < 0) r = (q > 65536) ? -65536 : -q;
          else         r = (q > 65535) ? 65535 : q;
        end
        res.result   = r[RES_W-1:0];
        res.exp_out  = '0;
        res.error    = vec_dropped;
        res.last_out = (j + 1 == vec_len);
        softmax_q.push_back(res);
      end
    end
    vec_len      = 0;
    vec_max      = -32768;
    vec_exp_sum  = 0;
    vec_grad_sum = 0;
    vec_dropped  = 1'b0;
  endtask

  // Result side: check on accept, then draw the next stall.
  always @(posedge clk_i or negedge rst_ni) begin : result_sink
    softmax_res_t exp_res;
    int           w;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      out_wait     <= 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (softmax_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %0d", out_if.result);
        end else begin
          exp_res = softmax_q.pop_front();
          if (out_if.result !== exp_res.result || out_if.exp_out !== exp_res.exp_out ||
              out_if.error !== exp_res.error || out_if.last_out !== exp_res.last_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp %0d/%0d/%0b/%0b got %0d/%0d/%0b/%0b",
                       exp_res.result, exp_res.exp_out, exp_res.error, exp_res.last_out,
                       out_if.result, out_if.exp_out, out_if.error, out_if.last_out);
          end
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 1'b0;
      end else if (out_if.valid && out_if.ready) begin
        w = no_gaps ? 0 : int'($urandom_range(0, 10));
        out_wait     <= w;
        out_if.ready <= (w == 0);
      end else if (out_wait > 0) begin
        out_wait     <= out_wait - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one item after a random gap; valid stays high across zero gaps.
  task automatic send_item(input logic signed [VAL_W-1:0] x, input logic [EXP_W-1:0] e_in,
                           input logic last);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.value  <= x;
    in_if.exp_in <= e_in;
    in_if.last   <= last;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    predict_softmax(x, e_in, last);
  endtask

  // Block idle: drop valid, wait until every owed result has been taken, then let the clock run on.
  task automatic drain_results();
    int guard;
    in_if.valid <= 1'b0;
    guard = 0;
    while (softmax_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_direction(input dir_e d);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= d;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    direction = d;
    @(posedge clk_i);
  endtask

  // Forward: single element saturates to 1.0, field extremes, far tails to 0.
  task automatic test_forward_extremes();
    write_direction(DIR_FORWARD);
    send_item(16'sd0, 17'd0, 1'b1);
    send_item(-16'sd32768, 17'd0, 1'b0);
    send_item(16'sd32767, 17'd131071, 1'b0);
    send_item(16'sd0, 17'd65536, 1'b0);
    send_item(-16'sd1, 17'd1, 1'b1);
    send_item(16'sd100, 17'd0, 1'b0);
    send_item(16'sd100, 17'd0, 1'b0);
    send_item(16'sd0, 17'd0, 1'b0);
    send_item(-16'sd2000, 17'd0, 1'b1);
    drain_results();
  endtask

  // Backward: zero sum, out-of-range exponents, gradient saturation both ways.
  task automatic test_backward_extremes();
    write_direction(DIR_BACKWARD);
    send_item(16'sd1234, 17'd0, 1'b0);
    send_item(-16'sd5, 17'd0, 1'b1);
    send_item(16'sd32767, 17'd131071, 1'b0);
    send_item(-16'sd32768, 17'd1, 1'b1);
    send_item(-16'sd32768, 17'd131071, 1'b0);
    send_item(16'sd32767, 17'd1, 1'b1);
    send_item(16'sd4096, 17'd65536, 1'b0);
    send_item(-16'sd4096, 17'd32768, 1'b0);
    send_item(16'sd0, 17'd100, 1'b1);
    drain_results();
  endtask

  // Over-long vectors: extra items dropped, the dropped last item still closes.
  task automatic test_overflow(input dir_e d);
    write_direction(d);
    for (int j = 0; j < MAX_LEN + 2; j++)
      send_item(VAL_W'($urandom_range(0, 16'hffff)), EXP_W'($urandom_range(0, 17'h1ffff)),
                1'b0);
    send_item(VAL_W'($urandom_range(0, 16'hffff)), EXP_W'($urandom_range(0, 17'h1ffff)),
              1'b1);
    drain_results();
  endtask

  task automatic send_random_vector(input int len);
    int base;
    logic signed [VAL_W-1:0] x;
    base = $signed($urandom_range(0, 16'hffff));
    for (int j = 0; j < len; j++) begin
      case ($urandom_range(0, 3))
        0:       x = VAL_W'($urandom_range(0, 16'hffff));
        default: x = VAL_W'(base + $signed($urandom_range(0, 8191)) - 4096);
      endcase
      send_item(x, ($urandom_range(0, 3) == 0) ? EXP_W'($urandom_range(0, 17'h1ffff))
                                                : EXP_W'($urandom_range(0, 65536)),
                j == len - 1);
    end
  endtask

  // Random vectors, mostly short, with the direction rewritten at random between some.
  task automatic test_random_vectors(input int items);
    int start, len;
    start = items_sent;
    while (items_sent - start < items) begin
      if ($urandom_range(0, 2) == 0) begin
        drain_results();
        write_direction(dir_e'($urandom_range(0, 1)));
      end
      no_gaps = ($urandom_range(0, 5) == 0);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 6);
      send_random_vector(len);
    end
    no_gaps = 1'b0;
    drain_results();
  endtask

  // Receiver holds off while the sender keeps offering the next vector.
  task automatic test_output_stall();
    write_direction(DIR_FORWARD);
    hold_cycles = 600;
    send_random_vector(5);
    send_random_vector(4);
    send_random_vector(3);
    drain_results();
  endtask

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_wdata_i  = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    in_if.exp_in = '0;
    in_if.last   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    items_sent   = 0;
    vectors_sent = 0;
    no_gaps      = 1'b0;
    hold_cycles  = 0;
    vec_len      = 0;
    vec_max      = -32768;
    vec_exp_sum  = 0;
    vec_grad_sum = 0;
    vec_dropped  = 1'b0;
    direction    = DIR_FORWARD;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_forward_extremes();
    test_backward_extremes();
    test_overflow(DIR_FORWARD);
    test_output_stall();
    test_random_vectors(10);
    test_overflow(DIR_BACKWARD);

    $display("covered %0d items in %0d vectors, %0d results, both directions, overflow",
             items_sent, vectors_sent, results_seen);
    if (mismatches == 0 && softmax_q.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, softmax_q.size());
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/smfb_pkg.sv
rtl/smfb_in_if.sv
rtl/smfb_out_if.sv
rtl/smfb_ram.sv
rtl/smfb_exp.sv
rtl/smfb_div.sv
rtl/softmax_forward_backward_core.sv
tb/tb_top.sv
